/* hdl/xcrd_pkg.sv */
// Shared types and constants for the XOR-checked response deframer.
package xcrd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MIN_W   = 3;
   localparam int unsigned POS_W   = 9;
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_BYTE   = 3'd1,
      KIND_FRAME  = 3'd2,
      KIND_ANSWER = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_TOO_SHORT = 3'd0,
      ERR_PREFIX    = 3'd1,
      ERR_COUNTER   = 3'd2,
      ERR_ADDRESS   = 3'd3,
      ERR_ZERO_LEN  = 3'd4,
      ERR_TRUNCATED = 3'd5,
      ERR_CHECKSUM  = 3'd6
   } err_type;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENT_ADDR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_ADDR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BROADCAST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BYTES  = 3'd5;

   localparam logic [BYTE_W-1:0] BROADCAST_RESET = 8'hFF;
   localparam logic [MIN_W-1:0]  MIN_BYTES_RESET = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] prefix_value;
      logic [BYTE_W-1:0] expected_counter;
      logic [BYTE_W-1:0] sent_address;
      logic [BYTE_W-1:0] no_address_value;
      logic [BYTE_W-1:0] broadcast_value;
      logic [MIN_W-1:0]  min_answer_bytes;
   } cfg_type;

   typedef struct packed {
      kind_type          result_kind;
      logic [BYTE_W-1:0] out_byte;
      err_type           error_code;
   } result_type;

endpackage

/* hdl/xcrd_ifs.sv */
// Valid/ready channel interfaces for received bytes and deframer results.
interface xcrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;

   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface xcrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [7:0] out_byte;
   logic [2:0] error_code;

   modport source (output valid, output result_kind, output out_byte, output error_code,
                   input ready);
   modport sink   (input valid, input result_kind, input out_byte, input error_code,
                   output ready);
endinterface

/* hdl/xcrd_csr.sv */
// Configuration register file of the deframer.
module xcrd_csr import xcrd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PREFIX:    cfg_in.prefix_value     = csr_data;
            CSR_COUNTER:   cfg_in.expected_counter = csr_data;
            CSR_SENT_ADDR: cfg_in.sent_address     = csr_data;
            CSR_NO_ADDR:   cfg_in.no_address_value = csr_data;
            CSR_BROADCAST: cfg_in.broadcast_value  = csr_data;
            CSR_MIN_BYTES: cfg_in.min_answer_bytes = csr_data[MIN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_value     <= '0;
         cfg_ff.expected_counter <= '0;
         cfg_ff.sent_address     <= '0;
         cfg_ff.no_address_value <= '0;
         cfg_ff.broadcast_value  <= BROADCAST_RESET;
         cfg_ff.min_answer_bytes <= MIN_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/xcrd_core.sv */
// Per-byte frame checker: frame state and the result of one byte.
module xcrd_core import xcrd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              last_byte,
   input  cfg_type           cfg,
   output result_type        result
);

   logic [POS_W-1:0]  pos_ff,    pos_in;
   logic [BYTE_W-1:0] len_ff,    len_in;
   logic [BYTE_W-1:0] xor_ff,    xor_in;
   logic              held_ff,   held_in;
   err_type           code_ff,   code_in;
   logic              failed_ff, failed_in;

   logic              provisional;
   logic              at_check;
   logic [POS_W:0]    count;
   logic              enough;
   logic              addr_bad;

   assign count  = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign enough = count >= (POS_W+1)'(cfg.min_answer_bytes);
   assign addr_bad = (rx_byte == cfg.no_address_value) || (rx_byte == cfg.broadcast_value) ||
                     ((rx_byte != cfg.sent_address) &&
                      (cfg.sent_address != cfg.broadcast_value));

   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      xor_in      = xor_ff;
      held_in     = held_ff;
      code_in     = code_ff;
      failed_in   = failed_ff;
      provisional = 1'b0;
      at_check    = 1'b0;
      result.result_kind = KIND_NONE;
      result.out_byte    = '0;
      result.error_code  = ERR_TOO_SHORT;

      if (failed_ff) begin
         // rest of a failed answer is dropped
         if (last_byte) begin
            pos_in = '0; len_in = '0; xor_in = '0; held_in = 1'b0; failed_in = 1'b0;
         end
      end else begin
         if (!held_ff) begin
            priority if (pos_ff == POS_W'(0)) begin
               xor_in = '0;
               if (rx_byte != cfg.prefix_value) begin
                  held_in = 1'b1; code_in = ERR_PREFIX;
               end
            end else if (pos_ff == POS_W'(1)) begin
               xor_in = rx_byte;
               if (rx_byte != cfg.expected_counter) begin
                  held_in = 1'b1; code_in = ERR_COUNTER;
               end
            end else if (pos_ff == POS_W'(2)) begin
               xor_in = xor_ff ^ rx_byte;
               if (addr_bad) begin
                  held_in = 1'b1; code_in = ERR_ADDRESS;
               end else begin
                  provisional = 1'b1;
               end
            end else if (pos_ff == POS_W'(3)) begin
               xor_in = xor_ff ^ rx_byte;
               len_in = rx_byte;
               if (rx_byte == '0) begin
                  held_in = 1'b1; code_in = ERR_ZERO_LEN;
               end else begin
                  provisional = 1'b1;
               end
            end else if (pos_ff < POS_W'(4) + POS_W'(len_ff)) begin
               xor_in = xor_ff ^ rx_byte;
               provisional = 1'b1;
            end else begin
               at_check = 1'b1;
            end
         end

         priority if (last_byte && !enough) begin
            result.result_kind = KIND_ERROR;
            result.error_code  = ERR_TOO_SHORT;
            pos_in = '0; len_in = '0; xor_in = '0; held_in = 1'b0; failed_in = 1'b0;
         end else if (held_in && enough) begin
            result.result_kind = KIND_ERROR;
            result.error_code  = code_in;
            if (last_byte) begin
               pos_in = '0; len_in = '0; xor_in = '0; held_in = 1'b0;
            end else begin
               failed_in = 1'b1;
            end
         end else if (at_check) begin
            pos_in = '0; len_in = '0; xor_in = '0; held_in = 1'b0;
            if (rx_byte != xor_ff) begin
               result.result_kind = KIND_ERROR;
               result.error_code  = ERR_CHECKSUM;
               failed_in = !last_byte;
            end else if (last_byte) begin
               result.result_kind = KIND_ANSWER;
            end else begin
               result.result_kind = KIND_FRAME;
            end
         end else if (last_byte) begin
            result.result_kind = KIND_ERROR;
            result.error_code  = ERR_TRUNCATED;
            pos_in = '0; len_in = '0; xor_in = '0; held_in = 1'b0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (provisional) begin
               result.result_kind = KIND_BYTE;
               result.out_byte    = rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         xor_ff    <= '0;
         held_ff   <= 1'b0;
         code_ff   <= ERR_TOO_SHORT;
         failed_ff <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         xor_ff    <= xor_in;
         held_ff   <= held_in;
         code_ff   <= code_in;
         failed_ff <= failed_in;
      end
   end

endmodule

/* hdl/xor_checked_response_deframer.sv */
// Top level of the XOR-checked response deframer.
// Usage:
//  - req: one received answer byte per transaction, last_byte marks the
//    final byte of the answer. rsp: exactly one result transaction per byte
//    (nothing, provisional byte, frame good, answer good or error + code).
//  - csr: write enable, index 0..5 and 8-bit data; the user must write it only
//    while no byte is in flight (unchecked). Indexes beyond 5 are ignored.
//  - Path: an accepted byte goes into the input register, the checker
//    works out its result from there, the result goes into the result
//    register and is offered on rsp from it.
//  - Throughput: one byte per cycle unless rsp stalls, held by the frame
//    state update in the checker between the input and result registers.
//  - Reset (synchronous): registers to defaults (broadcast 0xFF, minimum 6),
//    frame state cleared, both pipeline registers empty.
//  - rsp stall: the result register holds; the input register still takes
//    one more byte if empty, then req.ready drops until rsp drains.
module xor_checked_response_deframer import xcrd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   xcrd_req_if.sink             req_if,
   xcrd_rsp_if.source           rsp_if,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   cfg_type    cfg;
   result_type result;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // result register
   logic              out_valid_ff;
   result_type        out_ff;

   logic              step;

   // a byte is processed when the result register is free or draining
   assign step = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || step;

   xcrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   xcrd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.rx_byte;
         in_last_ff <= req_if.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_if.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_kind = out_ff.result_kind;
   assign rsp_if.out_byte    = out_ff.out_byte;
   assign rsp_if.error_code  = out_ff.error_code;

endmodule
